/* rtl/slsu_pkg.sv */
// ----------------------------------------------------------------------------
// slsu_pkg
// Shared types, sizes and codes for the stochastic lattice site update block.
// ----------------------------------------------------------------------------
package slsu_pkg;

   // Lattice geometry
   localparam int MAX_COLS   = 256;
   localparam int MAX_ROWS   = 256;
   localparam int LAT_DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = $clog2(LAT_DEPTH);

   // Field widths
   localparam int ROW_W      = 8;
   localparam int COL_W      = 8;
   localparam int DIR_W      = 2;
   localparam int DRAW_W     = 32;
   localparam int STATE_W    = 2;
   localparam int SIZE_W     = 9;
   localparam int THR_W      = 33;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 33;

   // Site states
   localparam logic [STATE_W-1:0] SITE_EMPTY   = 2'd0;
   localparam logic [STATE_W-1:0] SITE_DORMANT = 2'd1;
   localparam logic [STATE_W-1:0] SITE_ACTIVE  = 2'd2;

   // Request kinds
   localparam logic KIND_INIT   = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   // Neighbor directions
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WAKE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DIVISION  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DEATH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OCCUPANCY = 3'd5;

   localparam logic [SIZE_W-1:0] COLS_LIMIT = SIZE_W'(MAX_COLS);
   localparam logic [SIZE_W-1:0] ROWS_LIMIT = SIZE_W'(MAX_ROWS);
   localparam logic [SIZE_W-1:0] SIZE_ONE   = SIZE_W'(1);

   typedef struct packed {
      logic                kind;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic [DIR_W-1:0]    direction;
      logic [DRAW_W-1:0]   draw;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]    site_row;
      logic [COL_W-1:0]    site_col;
      logic [STATE_W-1:0]  old_state;
      logic [STATE_W-1:0]  new_state;
      logic                out_of_range;
   } rsp_type;

   // Size register value limited to 1..lim
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] lim);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_ONE;
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Linear lattice address, row major
   function automatic logic [ADDR_W-1:0] site_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(32'(r) * MAX_COLS + 32'(c));
   endfunction

endpackage

/* rtl/slsu_ram.sv */
// ----------------------------------------------------------------------------
// slsu_ram
// Generic synchronous RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module slsu_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

/* rtl/stochastic_lattice_site_update.sv */
// ----------------------------------------------------------------------------
// stochastic_lattice_site_update
// Toroidal lattice of empty / dormant / active sites with stochastic updates.
// ----------------------------------------------------------------------------
// After reset the block clears the lattice to empty, one site per cycle, and
// holds busy high until the last site is cleared; csr writes are taken meanwhile.
// Then, for each request, the site and its chosen neighbor are read together
// at the accept edge from the dual-read lattice RAM, and in the following
// cycle the new state is computed and written back. busy is high only during
// that write-back cycle, so no new request is accepted until it is done. The
// response is registered from the write-back cycle and shows up with rsp_valid
// for one cycle; it cannot be held off, so the receiver must take it.
// ----------------------------------------------------------------------------
module stochastic_lattice_site_update (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  slsu_pkg::req_type                  req_data,
   // response channel
   output logic                               rsp_valid,
   output slsu_pkg::rsp_type                  rsp_data,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [slsu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [slsu_pkg::CSR_DATA_W-1:0]    csr_data
);
   import slsu_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration. Sizes are stored already clamped to 1..MAX.
   // ---------------------------------------------------------------------
   logic [SIZE_W-1:0] cols_ff, cols_in;
   logic [SIZE_W-1:0] rows_ff, rows_in;
   logic [THR_W-1:0]  wake_ff, wake_in;
   logic [THR_W-1:0]  div_ff, div_in;
   logic [THR_W-1:0]  death_ff, death_in;
   logic [THR_W-1:0]  occ_ff, occ_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      wake_in  = wake_ff;
      div_in   = div_ff;
      death_in = death_ff;
      occ_in   = occ_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_GRID_COLS: cols_in  = clamp_size(csr_data[SIZE_W-1:0], COLS_LIMIT);
            REG_GRID_ROWS: rows_in  = clamp_size(csr_data[SIZE_W-1:0], ROWS_LIMIT);
            REG_WAKE:      wake_in  = csr_data[THR_W-1:0];
            REG_DIVISION:  div_in   = csr_data[THR_W-1:0];
            REG_DEATH:     death_in = csr_data[THR_W-1:0];
            REG_OCCUPANCY: occ_in   = csr_data[THR_W-1:0];
            default: ;  // unused index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= COLS_LIMIT;
         rows_ff  <= ROWS_LIMIT;
         wake_ff  <= '0;
         div_ff   <= '0;
         death_ff <= '0;
         occ_ff   <= '0;
      end else begin
         cols_ff  <= cols_in;
         rows_ff  <= rows_in;
         wake_ff  <= wake_in;
         div_ff   <= div_in;
         death_ff <= death_in;
         occ_ff   <= occ_in;
      end
   end

   // ---------------------------------------------------------------------
   // Clearing pass after reset
   // ---------------------------------------------------------------------
   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic              clear_last;

   assign clear_last = (clear_addr_ff == ADDR_W'(LAT_DEPTH - 1));

   always_comb begin
      clear_in      = clear_ff & ~clear_last;
      clear_addr_in = clear_ff ? clear_addr_ff + ADDR_W'(1) : clear_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // ---------------------------------------------------------------------
   // Accept stage: address of site and neighbor, range check
   // ---------------------------------------------------------------------
   logic              accept;
   logic              work_ff, work_in;
   req_type           req_ff;
   logic              oor_ff, oor_in;
   logic [ROW_W-1:0]  nbr_row;
   logic [COL_W-1:0]  nbr_col;
   logic [SIZE_W-1:0] row_ext, col_ext;
   logic [SIZE_W-1:0] row_up, col_up;

   assign busy   = clear_ff | work_ff;
   assign accept = start & ~busy;

   assign row_ext = {1'b0, req_data.row};
   assign col_ext = {1'b0, req_data.col};
   assign row_up  = row_ext + SIZE_ONE;
   assign col_up  = col_ext + SIZE_ONE;
   assign oor_in  = (row_ext >= rows_ff) | (col_ext >= cols_ff);

   // toroidal wrap over the sizes in use; size one wraps onto the site
   always_comb begin
      nbr_row = req_data.row;
      nbr_col = req_data.col;
      unique case (req_data.direction)
         DIR_UP: begin
            nbr_row = (req_data.row == '0) ? ROW_W'(rows_ff - SIZE_ONE)
                                           : req_data.row - ROW_W'(1);
         end
         DIR_RIGHT: begin
            nbr_col = (col_up >= cols_ff) ? '0 : col_up[COL_W-1:0];
         end
         DIR_DOWN: begin
            nbr_row = (row_up >= rows_ff) ? '0 : row_up[ROW_W-1:0];
         end
         DIR_LEFT: begin
            nbr_col = (req_data.col == '0) ? COL_W'(cols_ff - SIZE_ONE)
                                           : req_data.col - COL_W'(1);
         end
         default: ;
      endcase
   end

   assign work_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= 1'b0;
      end else begin
         work_ff <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
         oor_ff <= oor_in;
      end
   end

   // ---------------------------------------------------------------------
   // Lattice memory
   // ---------------------------------------------------------------------
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [STATE_W-1:0] ram_wr_data;
   logic [STATE_W-1:0] site_q, nbr_q;
   logic [ADDR_W-1:0]  upd_addr;
   logic [STATE_W-1:0] next_state;

   assign upd_addr    = site_addr(req_ff.row, req_ff.col);
   assign ram_wr_en   = clear_ff | (work_ff & ~oor_ff);
   assign ram_wr_addr = clear_ff ? clear_addr_ff : upd_addr;
   assign ram_wr_data = clear_ff ? SITE_EMPTY : next_state;

   slsu_ram #(
      .WIDTH (STATE_W),
      .DEPTH (LAT_DEPTH)
   ) u_lattice (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (accept),
      .rd_addr_a (site_addr(req_data.row, req_data.col)),
      .rd_addr_b (site_addr(nbr_row, nbr_col)),
      .rd_data_a (site_q),
      .rd_data_b (nbr_q)
   );

   // ---------------------------------------------------------------------
   // Update rules (cycle after accept)
   // ---------------------------------------------------------------------
   logic [THR_W-1:0]   draw_ext;
   logic [STATE_W-1:0] old_state;

   assign draw_ext  = {1'b0, req_ff.draw};
   assign old_state = oor_ff ? SITE_EMPTY : site_q;

   always_comb begin
      next_state = old_state;
      if (oor_ff) begin
         next_state = SITE_EMPTY;
      end else if (req_ff.kind == KIND_INIT) begin
         next_state = (draw_ext < occ_ff) ? SITE_DORMANT : SITE_EMPTY;
      end else begin
         unique case (site_q)
            SITE_EMPTY: begin
               if (nbr_q == SITE_ACTIVE && draw_ext < div_ff) begin
                  next_state = SITE_ACTIVE;
               end
            end
            SITE_DORMANT: begin
               if (draw_ext < wake_ff) begin
                  next_state = SITE_ACTIVE;
               end
            end
            SITE_ACTIVE: begin
               if (draw_ext < death_ff) begin
                  next_state = SITE_EMPTY;
               end
            end
            default: ;  // unused code, never written
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign rsp_valid_in = work_ff;

   always_comb begin
      rsp_data_in.site_row     = req_ff.row;
      rsp_data_in.site_col     = req_ff.col;
      rsp_data_in.old_state    = old_state;
      rsp_data_in.new_state    = next_state;
      rsp_data_in.out_of_range = oor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/slsu_checker.sv */
// ----------------------------------------------------------------------------
// slsu_checker
// Port-level checks for the stochastic lattice site update block.
// ----------------------------------------------------------------------------
module slsu_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input slsu_pkg::rsp_type rsp_data
);
   import slsu_pkg::*;

   // an accepted request raises busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // every accepted request is followed by its response
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("response missing after accept");

   // no response without an earlier accepted request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without request");

   // an out-of-range site reports empty before and after
   a_oor_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_range) |->
         (rsp_data.old_state == SITE_EMPTY && rsp_data.new_state == SITE_EMPTY))
      else $error("out-of-range response carries a state");

endmodule

bind stochastic_lattice_site_update slsu_checker u_slsu_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
